[src/ttb_pkg.sv]
// Shared constants, command types and index helpers for the text terminal buffer.
`default_nettype none

package ttb_pkg;

    // Grid geometry.
    localparam int COLS   = 53;
    localparam int ROWS   = 24;
    localparam int CELLS  = ROWS * COLS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CNT_W  = $clog2(CELLS + 1);
    localparam int SRC_W  = ADDR_W + 1;

    // Field widths.
    localparam int OP_W    = 3;
    localparam int CHAR_W  = 8;
    localparam int AMT_W   = 8;
    localparam int COLOR_W = 4;
    localparam int COL_W   = 6;
    localparam int ROW_W   = 5;
    localparam int GLYPH_W = 7;
    localparam int ATTR_W  = 8;
    localparam int CELL_W  = GLYPH_W + ATTR_W;
    localparam int IDX_W   = ROW_W + COL_W + 1;

    // Command queue depth between the front and back ends.
    localparam int QDEPTH = 2;
    localparam int QP_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QC_W   = $clog2(QDEPTH + 1);

    // Configuration register indexes.
    localparam logic CFG_FG = 1'b0;
    localparam logic CFG_BG = 1'b1;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_PUT     = OP_W'(0);
    localparam logic [OP_W-1:0] OP_CLEAR   = OP_W'(1);
    localparam logic [OP_W-1:0] OP_SCROLL  = OP_W'(2);
    localparam logic [OP_W-1:0] OP_SET_CUR = OP_W'(3);
    localparam logic [OP_W-1:0] OP_READ    = OP_W'(4);

    // Character codes with special handling.
    localparam logic [CHAR_W-1:0] CHAR_NL    = CHAR_W'(10);
    localparam logic [CHAR_W-1:0] CHAR_FIRST = CHAR_W'(32);
    localparam logic [CHAR_W-1:0] CHAR_LAST  = CHAR_W'(127);

    // Classified command kinds.
    typedef enum logic [3:0] {
        K_NOP,
        K_PRINT,
        K_NEWLINE,
        K_PUT_NONE,
        K_CLEAR,
        K_SCROLL_UP,
        K_SCROLL_DN,
        K_SET_CUR,
        K_READ
    } kind_t;

    // One classified command as it travels from the front to the back end.
    typedef struct packed {
        kind_t               kind;
        logic [CELL_W-1:0]   cell_bits;
        logic [ADDR_W-1:0]   off;
        logic [ADDR_W-1:0]   addr;
        logic [COL_W-1:0]    col;
        logic [ROW_W-1:0]    row;
    } cmd_t;

    // Linear cell index of a row and column.
    function automatic logic [ADDR_W-1:0] cell_index(input logic [ROW_W-1:0] r,
                                                      input logic [COL_W-1:0] c);
        logic [IDX_W-1:0] p;
        p = IDX_W'(r) * IDX_W'(COLS) + IDX_W'(c);
        return p[ADDR_W-1:0];
    endfunction

endpackage

`default_nettype wire

[src/ttb_front.sv]
// Front end: accepts input transfers and classifies them into commands.
`default_nettype none

module ttb_front
    import ttb_pkg::*;
(
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  wire  [OP_W-1:0]     s_op,
    input  wire  [CHAR_W-1:0]   s_char_code,
    input  wire  [AMT_W-1:0]    s_scroll_amount,
    input  wire  [COLOR_W-1:0]  s_clear_color,
    input  wire  [COL_W-1:0]    s_col,
    input  wire  [ROW_W-1:0]    s_row,
    input  wire  [COLOR_W-1:0]  fore_color,
    input  wire  [COLOR_W-1:0]  back_color,
    input  wire                 init_busy,
    output logic                cmd_valid,
    output cmd_t                cmd,
    input  wire                 cmd_ready
);

    logic              valid_reg;
    logic              valid_next;
    cmd_t              cmd_reg;
    cmd_t              dec;
    logic [AMT_W-1:0]  mag;
    logic [ROW_W-1:0]  rows_sat;
    logic [CHAR_W-1:0] glyph_full;
    logic              accept;

    // Decode the incoming item.
    always_comb begin
        dec        = '0;
        dec.kind   = K_NOP;
        mag        = s_scroll_amount[AMT_W-1] ? (~s_scroll_amount + AMT_W'(1))
                                              : s_scroll_amount;
        rows_sat   = (mag > AMT_W'(ROWS)) ? ROW_W'(ROWS) : mag[ROW_W-1:0];
        glyph_full = s_char_code - CHAR_FIRST;

        case (s_op)
            OP_PUT: begin
                if (s_char_code == CHAR_NL) begin
                    dec.kind = K_NEWLINE;
                end else if (s_char_code inside {[CHAR_FIRST:CHAR_LAST]}) begin
                    dec.kind = K_PRINT;
                end else begin
                    dec.kind = K_PUT_NONE;
                end
                dec.cell_bits = {glyph_full[GLYPH_W-1:0], fore_color, back_color};
            end
            OP_CLEAR: begin
                dec.kind      = K_CLEAR;
                dec.cell_bits = CELL_W'(s_clear_color);
            end
            OP_SCROLL: begin
                if (s_scroll_amount == '0) begin
                    dec.kind = K_NOP;
                end else if (s_scroll_amount[AMT_W-1]) begin
                    dec.kind = K_SCROLL_DN;
                end else begin
                    dec.kind = K_SCROLL_UP;
                end
                dec.off = cell_index(rows_sat, '0);
            end
            OP_SET_CUR: begin
                dec.kind = K_SET_CUR;
                dec.col  = (s_col < COL_W'(COLS)) ? s_col : COL_W'(COLS - 1);
                dec.row  = (s_row < ROW_W'(ROWS)) ? s_row : ROW_W'(ROWS);
            end
            OP_READ: begin
                if (s_col < COL_W'(COLS) && s_row < ROW_W'(ROWS)) begin
                    dec.kind = K_READ;
                end
                dec.addr = cell_index(s_row, s_col);
            end
            default: begin
                dec.kind = K_NOP;
            end
        endcase
    end

    // Single holding stage in front of the queue.
    assign s_ready   = (!valid_reg || cmd_ready) && !init_busy;
    assign accept    = s_valid && s_ready;
    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

    always_comb begin
        valid_next = valid_reg;
        if (valid_reg && cmd_ready) begin
            valid_next = 1'b0;
        end
        if (accept) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (accept) begin
            cmd_reg <= dec;
        end
    end

endmodule

`default_nettype wire

[src/ttb_queue.sv]
// Short command queue between the front and back ends.
`default_nettype none

module ttb_queue
    import ttb_pkg::*;
(
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         push_valid,
    output logic        push_ready,
    input  wire cmd_t   push_cmd,
    output logic        pop_valid,
    output cmd_t        pop_cmd,
    input  wire         pop
);

    cmd_t              entry_reg [QDEPTH];
    logic [QP_W-1:0]   wr_ptr_reg;
    logic [QP_W-1:0]   wr_ptr_next;
    logic [QP_W-1:0]   rd_ptr_reg;
    logic [QP_W-1:0]   rd_ptr_next;
    logic [QC_W-1:0]   count_reg;
    logic [QC_W-1:0]   count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != QC_W'(QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QP_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + QP_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QP_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + QP_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + QC_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - QC_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

[src/ttb_back.sv]
// Back end: cell memory, cursor, grid sweeps and the result register.
`default_nettype none

module ttb_back
    import ttb_pkg::*;
(
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 cmd_valid,
    input  wire cmd_t           cmd,
    output logic                cmd_pop,
    input  wire  [COLOR_W-1:0]  back_color,
    output logic                init_busy,
    output logic                m_valid,
    input  wire                 m_ready,
    output logic [COL_W-1:0]    m_cursor_col,
    output logic [ROW_W-1:0]    m_cursor_row,
    output logic [GLYPH_W-1:0]  m_cell_glyph,
    output logic [ATTR_W-1:0]   m_cell_attr
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_READ
    } state_t;

    // Cell memory: glyph in the upper bits, attribute in the lower byte.
    logic [CELL_W-1:0]  mem [CELLS];
    logic [CELL_W-1:0]  rd_data_reg;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic [CELL_W-1:0]  wr_data;

    state_t             state_reg,     state_next;
    logic               init_reg,      init_next;
    logic               hold_valid_reg, hold_valid_next;
    cmd_t               hold_reg,      hold_next;
    logic [COL_W-1:0]   cur_col_reg,   cur_col_next;
    logic [ROW_W-1:0]   cur_row_reg,   cur_row_next;
    logic [ADDR_W-1:0]  sw_addr_reg,   sw_addr_next;
    logic [CNT_W-1:0]   sw_cnt_reg,    sw_cnt_next;
    logic               sw_up_reg,     sw_up_next;
    logic [ADDR_W-1:0]  sw_off_reg,    sw_off_next;
    logic [CELL_W-1:0]  sw_fill_reg,   sw_fill_next;
    logic               sw_post_reg,   sw_post_next;
    logic               wr_pend_reg,   wr_pend_next;
    logic [ADDR_W-1:0]  wr_addr_reg,   wr_addr_next;
    logic               wr_copy_reg,   wr_copy_next;
    logic               res_valid_reg, res_valid_next;
    logic [COL_W-1:0]   res_col_reg,   res_col_next;
    logic [ROW_W-1:0]   res_row_reg,   res_row_next;
    logic [GLYPH_W-1:0] res_glyph_reg, res_glyph_next;
    logic [ATTR_W-1:0]  res_attr_reg,  res_attr_next;

    cmd_t               cur_cmd;
    logic               go;
    logic               post;
    logic [CELL_W-1:0]  post_cell;
    logic [ADDR_W-1:0]  cursor_idx;
    logic [COL_W-1:0]   col_inc;
    logic [SRC_W-1:0]   src_up;
    logic [ADDR_W-1:0]  src_dn;
    logic               sweep_copy;
    logic [ADDR_W-1:0]  sweep_src;

    // Source of the cell being swept: a later cell for upward moves, an earlier one for
    // downward moves.
    always_comb begin
        src_up     = SRC_W'(sw_addr_reg) + SRC_W'(sw_off_reg);
        src_dn     = sw_addr_reg - sw_off_reg;
        sweep_copy = sw_up_reg ? (src_up < SRC_W'(CELLS)) : (sw_addr_reg >= sw_off_reg);
        sweep_src  = sw_up_reg ? src_up[ADDR_W-1:0] : src_dn;
    end

    assign cur_cmd    = hold_valid_reg ? hold_reg : cmd;
    assign cursor_idx = cell_index(cur_row_reg, cur_col_reg);
    assign col_inc    = cur_col_reg + COL_W'(1);
    assign go         = (state_reg == ST_IDLE) && (hold_valid_reg || cmd_valid)
                        && (!res_valid_reg || m_ready) && !wr_pend_reg;

    // Sequencer: starts commands, runs sweeps and posts results.
    always_comb begin
        state_next      = state_reg;
        init_next       = init_reg;
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        cur_col_next    = cur_col_reg;
        cur_row_next    = cur_row_reg;
        sw_addr_next    = sw_addr_reg;
        sw_cnt_next     = sw_cnt_reg;
        sw_up_next      = sw_up_reg;
        sw_off_next     = sw_off_reg;
        sw_fill_next    = sw_fill_reg;
        sw_post_next    = sw_post_reg;
        wr_pend_next    = 1'b0;
        wr_addr_next    = wr_addr_reg;
        wr_copy_next    = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = sweep_src;
        cmd_pop         = 1'b0;
        post            = 1'b0;
        post_cell       = '0;

        case (state_reg)
            ST_IDLE: begin
                if (go) begin
                    cmd_pop         = !hold_valid_reg;
                    hold_valid_next = 1'b0;
                    case (cur_cmd.kind)
                        K_PRINT, K_NEWLINE, K_PUT_NONE: begin
                            if (cur_row_reg >= ROW_W'(ROWS)) begin
                                // Pending scroll: move the grid up one row first.
                                hold_valid_next = 1'b1;
                                hold_next       = cur_cmd;
                                cur_row_next    = ROW_W'(ROWS - 1);
                                sw_addr_next    = '0;
                                sw_cnt_next     = CNT_W'(CELLS);
                                sw_up_next      = 1'b1;
                                sw_off_next     = ADDR_W'(COLS);
                                sw_fill_next    = CELL_W'(back_color);
                                sw_post_next    = 1'b0;
                                state_next      = ST_SWEEP;
                            end else if (cur_cmd.kind == K_PRINT) begin
                                sw_addr_next = cursor_idx;
                                sw_cnt_next  = CNT_W'(1);
                                sw_up_next   = 1'b1;
                                sw_off_next  = ADDR_W'(CELLS);
                                sw_fill_next = cur_cmd.cell_bits;
                                sw_post_next = 1'b1;
                                state_next   = ST_SWEEP;
                                if (col_inc == COL_W'(COLS)) begin
                                    cur_col_next = '0;
                                    cur_row_next = cur_row_reg + ROW_W'(1);
                                end else begin
                                    cur_col_next = col_inc;
                                end
                            end else if (cur_cmd.kind == K_NEWLINE) begin
                                sw_addr_next = cursor_idx;
                                sw_cnt_next  = CNT_W'(COLS) - CNT_W'(cur_col_reg);
                                sw_up_next   = 1'b1;
                                sw_off_next  = ADDR_W'(CELLS);
                                sw_fill_next = CELL_W'(back_color);
                                sw_post_next = 1'b1;
                                state_next   = ST_SWEEP;
                                cur_col_next = '0;
                                cur_row_next = cur_row_reg + ROW_W'(1);
                            end else begin
                                post = 1'b1;
                            end
                        end
                        K_CLEAR: begin
                            sw_addr_next = '0;
                            sw_cnt_next  = CNT_W'(CELLS);
                            sw_up_next   = 1'b1;
                            sw_off_next  = ADDR_W'(CELLS);
                            sw_fill_next = cur_cmd.cell_bits;
                            sw_post_next = 1'b1;
                            state_next   = ST_SWEEP;
                            cur_col_next = '0;
                            cur_row_next = '0;
                        end
                        K_SCROLL_UP: begin
                            sw_addr_next = '0;
                            sw_cnt_next  = CNT_W'(CELLS);
                            sw_up_next   = 1'b1;
                            sw_off_next  = cur_cmd.off;
                            sw_fill_next = CELL_W'(back_color);
                            sw_post_next = 1'b1;
                            state_next   = ST_SWEEP;
                        end
                        K_SCROLL_DN: begin
                            sw_addr_next = ADDR_W'(CELLS - 1);
                            sw_cnt_next  = CNT_W'(CELLS);
                            sw_up_next   = 1'b0;
                            sw_off_next  = cur_cmd.off;
                            sw_fill_next = CELL_W'(back_color);
                            sw_post_next = 1'b1;
                            state_next   = ST_SWEEP;
                        end
                        K_SET_CUR: begin
                            cur_col_next = cur_cmd.col;
                            cur_row_next = cur_cmd.row;
                            post         = 1'b1;
                        end
                        K_READ: begin
                            rd_en      = 1'b1;
                            rd_addr    = cur_cmd.addr;
                            state_next = ST_READ;
                        end
                        default: begin
                            post = 1'b1;
                        end
                    endcase
                end
            end
            ST_SWEEP: begin
                // Read the source cell now and write the target in the following cycle.
                rd_en        = sweep_copy;
                rd_addr      = sweep_src;
                wr_pend_next = 1'b1;
                wr_addr_next = sw_addr_reg;
                wr_copy_next = sweep_copy;
                sw_addr_next = sw_up_reg ? sw_addr_reg + ADDR_W'(1)
                                         : sw_addr_reg - ADDR_W'(1);
                sw_cnt_next  = sw_cnt_reg - CNT_W'(1);
                if (sw_cnt_reg == CNT_W'(1)) begin
                    state_next = ST_IDLE;
                    init_next  = 1'b0;
                    post       = sw_post_reg;
                end
            end
            ST_READ: begin
                post       = 1'b1;
                post_cell  = rd_data_reg;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Result register.
        res_valid_next = res_valid_reg;
        res_col_next   = res_col_reg;
        res_row_next   = res_row_reg;
        res_glyph_next = res_glyph_reg;
        res_attr_next  = res_attr_reg;
        if (res_valid_reg && m_ready) begin
            res_valid_next = 1'b0;
        end
        if (post) begin
            res_valid_next = 1'b1;
            res_col_next   = cur_col_next;
            res_row_next   = cur_row_next;
            res_glyph_next = post_cell[CELL_W-1:ATTR_W];
            res_attr_next  = post_cell[ATTR_W-1:0];
        end
    end

    // State and registered outputs. Reset starts the clearing pass over the grid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_SWEEP;
            init_reg       <= 1'b1;
            hold_valid_reg <= 1'b0;
            cur_col_reg    <= '0;
            cur_row_reg    <= '0;
            sw_addr_reg    <= '0;
            sw_cnt_reg     <= CNT_W'(CELLS);
            sw_up_reg      <= 1'b1;
            sw_off_reg     <= ADDR_W'(CELLS);
            sw_fill_reg    <= '0;
            sw_post_reg    <= 1'b0;
            wr_pend_reg    <= 1'b0;
            wr_copy_reg    <= 1'b0;
            res_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            init_reg       <= init_next;
            hold_valid_reg <= hold_valid_next;
            cur_col_reg    <= cur_col_next;
            cur_row_reg    <= cur_row_next;
            sw_addr_reg    <= sw_addr_next;
            sw_cnt_reg     <= sw_cnt_next;
            sw_up_reg      <= sw_up_next;
            sw_off_reg     <= sw_off_next;
            sw_fill_reg    <= sw_fill_next;
            sw_post_reg    <= sw_post_next;
            wr_pend_reg    <= wr_pend_next;
            wr_copy_reg    <= wr_copy_next;
            res_valid_reg  <= res_valid_next;
        end
        hold_reg      <= hold_next;
        wr_addr_reg   <= wr_addr_next;
        res_col_reg   <= res_col_next;
        res_row_reg   <= res_row_next;
        res_glyph_reg <= res_glyph_next;
        res_attr_reg  <= res_attr_next;
    end

    // Cell memory: one write port, one registered read port.
    assign wr_data = wr_copy_reg ? rd_data_reg : sw_fill_reg;

    always_ff @(posedge aclk) begin
        if (wr_pend_reg) begin
            mem[wr_addr_reg] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign init_busy    = init_reg;
    assign m_valid      = res_valid_reg;
    assign m_cursor_col = res_col_reg;
    assign m_cursor_row = res_row_reg;
    assign m_cell_glyph = res_glyph_reg;
    assign m_cell_attr  = res_attr_reg;

    // The cursor row never goes past the pending-scroll position.
    a_row_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_row_reg <= ROW_W'(ROWS))
        else $error("cursor row beyond pending-scroll position");

    // A held character always waits with the cursor on the last row.
    a_hold_row: assert property (@(posedge aclk) disable iff (!aresetn)
        hold_valid_reg |-> cur_row_reg == ROW_W'(ROWS - 1))
        else $error("held character without cursor on last row");

    // No command leaves the queue during the clearing pass.
    a_init_no_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        init_reg |-> !cmd_pop)
        else $error("command taken during clearing pass");

    // Sweep writes stay inside the grid.
    a_wr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_pend_reg |-> SRC_W'(wr_addr_reg) < SRC_W'(CELLS))
        else $error("cell write outside the grid");

    // A read result is posted to the result register from the read state.
    a_read_post: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ) |=> res_valid_reg)
        else $error("read result not posted");

endmodule

`default_nettype wire

[src/text_terminal_buffer_top.sv]
// Top level of the text terminal buffer: color registers, front end, queue and back end.
//
// The block holds a 24 x 53 grid of glyph/attribute cells in a single-port-write
// memory and a cursor, and answers every operation with one result transfer. After
// reset a clearing pass walks all 1272 cells of the grid (one cell per cycle) before
// the first operation is accepted; configuration writes are taken throughout.
// Operation cost is set by the cell memory, which moves one cell per cycle: clear
// and scroll walk the whole grid, a newline blanks the rest of its row, a printable
// character writes one cell and a cell read reads one; set cursor, carriage return,
// ignored codes and unused ops touch no cell. A character sent while a scroll is
// pending first adds one upward scroll of the whole grid. Up to three operations
// are buffered ahead of the back end, so input transfers continue while a result waits.
`default_nettype none

module text_terminal_buffer_top
    import ttb_pkg::*;
(
    input  wire                 aclk,
    input  wire                 aresetn,
    // Input channel.
    input  wire                 s_valid,
    output logic                s_ready,
    input  wire  [OP_W-1:0]     s_op,
    input  wire  [CHAR_W-1:0]   s_char_code,
    input  wire  signed [AMT_W-1:0] s_scroll_amount,
    input  wire  [COLOR_W-1:0]  s_clear_color,
    input  wire  [COL_W-1:0]    s_col,
    input  wire  [ROW_W-1:0]    s_row,
    // Result channel.
    output logic                m_valid,
    input  wire                 m_ready,
    output logic [COL_W-1:0]    m_cursor_col,
    output logic [ROW_W-1:0]    m_cursor_row,
    output logic [GLYPH_W-1:0]  m_cell_glyph,
    output logic [ATTR_W-1:0]   m_cell_attr,
    // Configuration write channel.
    input  wire                 cfg_valid,
    output logic                cfg_ready,
    input  wire                 cfg_index,
    input  wire  [COLOR_W-1:0]  cfg_data
);

    localparam logic [COLOR_W-1:0]  FG_RESET = COLOR_W'(8);
    localparam logic [COLOR_W-1:0]  BG_RESET = COLOR_W'(0);

    logic [COLOR_W-1:0] fg_reg, fg_next;
    logic [COLOR_W-1:0] bg_reg, bg_next;
    logic               init_busy;
    logic               f_valid;
    cmd_t               f_cmd;
    logic               q_ready;
    logic               q_valid;
    cmd_t               q_cmd;
    logic               q_pop;

    // Color registers.
    assign cfg_ready = 1'b1;

    always_comb begin
        fg_next = fg_reg;
        bg_next = bg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_FG:  fg_next = cfg_data;
                CFG_BG:  bg_next = cfg_data;
                default: fg_next = fg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fg_reg <= FG_RESET;
            bg_reg <= BG_RESET;
        end else begin
            fg_reg <= fg_next;
            bg_reg <= bg_next;
        end
    end

    ttb_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_char_code     (s_char_code),
        .s_scroll_amount (s_scroll_amount),
        .s_clear_color   (s_clear_color),
        .s_col           (s_col),
        .s_row           (s_row),
        .fore_color      (fg_reg),
        .back_color      (bg_reg),
        .init_busy       (init_busy),
        .cmd_valid       (f_valid),
        .cmd             (f_cmd),
        .cmd_ready       (q_ready)
    );

    ttb_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (f_valid),
        .push_ready (q_ready),
        .push_cmd   (f_cmd),
        .pop_valid  (q_valid),
        .pop_cmd    (q_cmd),
        .pop        (q_pop)
    );

    ttb_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd_valid    (q_valid),
        .cmd          (q_cmd),
        .cmd_pop      (q_pop),
        .back_color   (bg_reg),
        .init_busy    (init_busy),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_cursor_col (m_cursor_col),
        .m_cursor_row (m_cursor_row),
        .m_cell_glyph (m_cell_glyph),
        .m_cell_attr  (m_cell_attr)
    );

endmodule

`default_nettype wire

[bench/tb_text_terminal_buffer_top.sv]
// Self-checking testbench for the text terminal buffer: grid predictor, scoreboard and drivers.
`timescale 1ns / 100ps

module tb_text_terminal_buffer_top;
    import ttb_pkg::*;

    // Codes and limits used by the bench.
    localparam logic [COLOR_W-1:0] FG_AT_RESET   = COLOR_W'(8);
    localparam logic [COLOR_W-1:0] BG_AT_RESET   = COLOR_W'(0);
    localparam logic [CHAR_W-1:0] CHAR_CR        = CHAR_W'(13);
    localparam logic [OP_W-1:0]   OP_SPARE_FIRST = OP_READ + OP_W'(1);
    localparam logic [OP_W-1:0]   OP_SPARE_LAST  = '1;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 190;
    localparam int DRAIN_CYCLES    = 3000;
    localparam int QUIET_LIMIT     = 20000;
    localparam int REPORT_LIMIT    = 10;

    // One command as presented on the input channel.
    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [CHAR_W-1:0]  code;
        logic [AMT_W-1:0]   amount;
        logic [COLOR_W-1:0] clear_color;
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
    } term_cmd_t;

    // One status word as returned on the result channel.
    typedef struct packed {
        logic [COL_W-1:0]   cursor_col;
        logic [ROW_W-1:0]   cursor_row;
        logic [GLYPH_W-1:0] glyph;
        logic [ATTR_W-1:0]  attr;
    } term_status_t;

    // Shadow copy of the screen plus the queue of status words still owed by the block.
    class screen_scoreboard;
        logic [GLYPH_W-1:0] glyph_cells [CELLS];
        logic [ATTR_W-1:0]  attr_cells [CELLS];
        int                 cur_col;
        int                 cur_row;
        logic [COLOR_W-1:0] fg;
        logic [COLOR_W-1:0] bg;
        term_status_t       status_due [$];
        int                 mismatches;
        int                 results_seen;

        function new();
            for (int i = 0; i < CELLS; i++) begin
                glyph_cells[i] = '0;
                attr_cells[i]  = '0;
            end
            cur_col      = 0;
            cur_row      = 0;
            fg           = FG_AT_RESET;
            bg           = BG_AT_RESET;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function void set_color(logic index, logic [COLOR_W-1:0] data);
            if (index == CFG_BG) bg = data;
            else fg = data;
        endfunction

        function void blank_row(int r);
            for (int k = 0; k < COLS; k++) begin
                glyph_cells[r * COLS + k] = '0;
                attr_cells[r * COLS + k]  = ATTR_W'(bg);
            end
        endfunction

        function void move_row(int dst, int src);
            for (int k = 0; k < COLS; k++) begin
                glyph_cells[dst * COLS + k] = glyph_cells[src * COLS + k];
                attr_cells[dst * COLS + k]  = attr_cells[src * COLS + k];
            end
        endfunction

        // Positive counts move content up, negative move it down; vacated rows are blanked.
        function void scroll_grid(int n);
            int mag;
            mag = (n < 0) ? -n : n;
            if (mag > ROWS) mag = ROWS;
            if (n > 0) begin
                for (int r = 0; r < ROWS; r++) begin
                    if (r + mag < ROWS) move_row(r, r + mag);
                    else blank_row(r);
                end
            end else if (n < 0) begin
                for (int r = ROWS - 1; r >= 0; r--) begin
                    if (r >= mag) move_row(r, r - mag);
                    else blank_row(r);
                end
            end
        endfunction

        // A pending cursor row below the grid is resolved by scrolling before the character.
        function void put_char(logic [CHAR_W-1:0] code);
            int idx;
            if (cur_row >= ROWS) begin
                scroll_grid(cur_row - ROWS + 1);
                cur_row = ROWS - 1;
            end
            idx = cur_row * COLS + cur_col;
            if (code == CHAR_NL) begin
                for (int k = cur_col; k < COLS; k++) begin
                    glyph_cells[cur_row * COLS + k] = '0;
                    attr_cells[cur_row * COLS + k]  = ATTR_W'(bg);
                end
                cur_row++;
                cur_col = 0;
            end else if (code == CHAR_CR) begin
                // Carriage return leaves everything as it is.
            end else if (code >= CHAR_FIRST && code <= CHAR_LAST) begin
                glyph_cells[idx] = GLYPH_W'(code - CHAR_FIRST);
                attr_cells[idx]  = {fg, bg};
                cur_col++;
                if (cur_col >= COLS) begin
                    cur_col = 0;
                    cur_row++;
                end
            end
        endfunction

        // Applies one command to the shadow screen and returns the status it must produce.
        function term_status_t apply_command(term_cmd_t c);
            term_status_t s;
            int           idx;
            s.glyph = '0;
            s.attr  = '0;
            case (c.op)
                OP_PUT: put_char(c.code);
                OP_CLEAR: begin
                    for (int i = 0; i < CELLS; i++) begin
                        glyph_cells[i] = '0;
                        attr_cells[i]  = ATTR_W'(c.clear_color);
                    end
                    cur_col = 0;
                    cur_row = 0;
                end
                OP_SCROLL: scroll_grid(int'($signed(c.amount)));
                OP_SET_CUR: begin
                    cur_col = (int'(c.col) < COLS) ? int'(c.col) : COLS - 1;
                    cur_row = (int'(c.row) < ROWS) ? int'(c.row) : ROWS;
                end
                OP_READ: begin
                    if (int'(c.col) < COLS && int'(c.row) < ROWS) begin
                        idx     = int'(c.row) * COLS + int'(c.col);
                        s.glyph = glyph_cells[idx];
                        s.attr  = attr_cells[idx];
                    end
                end
                default: ;
            endcase
            s.cursor_col = COL_W'(cur_col);
            s.cursor_row = ROW_W'(cur_row);
            return s;
        endfunction

        function void note_command(term_cmd_t c);
            status_due.push_back(apply_command(c));
        endfunction

        function void check_status(logic [COL_W-1:0] col, logic [ROW_W-1:0] row,
                                   logic [GLYPH_W-1:0] glyph, logic [ATTR_W-1:0] attr);
            term_status_t want;
            results_seen++;
            if (status_due.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("ERROR: unexpected result %0d: col %0d row %0d glyph %0d attr %02h",
                             results_seen, col, row, glyph, attr);
                return;
            end
            want = status_due.pop_front();
            if (col !== want.cursor_col || row !== want.cursor_row ||
                glyph !== want.glyph || attr !== want.attr) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display({"ERROR: result %0d: col exp %0d got %0d, row exp %0d got %0d, ",
                              "glyph exp %0d got %0d, attr exp %02h got %02h"},
                             results_seen, want.cursor_col, col, want.cursor_row, row,
                             want.glyph, glyph, want.attr, attr);
            end
        endfunction

        function int pending();
            return status_due.size();
        endfunction
    endclass

    // Clock, reset and block ports.
    logic               aclk;
    logic               aresetn         = 1'b0;
    logic               s_valid         = 1'b0;
    logic               s_ready;
    logic [OP_W-1:0]    s_op            = '0;
    logic [CHAR_W-1:0]  s_char_code     = '0;
    logic [AMT_W-1:0]   s_scroll_amount = '0;
    logic [COLOR_W-1:0] s_clear_color   = '0;
    logic [COL_W-1:0]   s_col           = '0;
    logic [ROW_W-1:0]   s_row           = '0;
    logic               m_valid;
    logic               m_ready         = 1'b0;
    logic [COL_W-1:0]   m_cursor_col;
    logic [ROW_W-1:0]   m_cursor_row;
    logic [GLYPH_W-1:0] m_cell_glyph;
    logic [ATTR_W-1:0]  m_cell_attr;
    logic               cfg_valid       = 1'b0;
    logic               cfg_ready;
    logic               cfg_index       = 1'b0;
    logic [COLOR_W-1:0] cfg_data        = '0;

    screen_scoreboard board = new();
    bit               sender_steady = 1'b0;
    int unsigned      quiet_cycles  = 0;

    text_terminal_buffer_top DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_char_code     (s_char_code),
        .s_scroll_amount (s_scroll_amount),
        .s_clear_color   (s_clear_color),
        .s_col           (s_col),
        .s_row           (s_row),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_cursor_col    (m_cursor_col),
        .m_cursor_row    (m_cursor_row),
        .m_cell_glyph    (m_cell_glyph),
        .m_cell_attr     (m_cell_attr),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Every result transfer is checked against the oldest expected status.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_status(m_cursor_col, m_cursor_row, m_cell_glyph, m_cell_attr);
    end

    // Watchdog on cycles without any transfer on any channel.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("ERROR: no transfer for %0d cycles", quiet_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Result side back-pressure: mostly short stalls, a few long ones, and long ready runs.
    initial begin : ready_pattern
        int unsigned run_len;
        int unsigned stall_len;
        @(posedge aclk);
        forever begin
            run_len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 8)
                                                   : $urandom_range(50, 300);
            m_ready <= 1'b1;
            repeat (run_len) @(posedge aclk);
            case ($urandom_range(0, 99)) inside
                [0:69]:  stall_len = 0;
                [70:91]: stall_len = $urandom_range(1, 4);
                default: stall_len = $urandom_range(20, 60);
            endcase
            if (stall_len != 0) begin
                m_ready <= 1'b0;
                repeat (stall_len) @(posedge aclk);
            end
        end
    end

    function automatic int sender_gap();
        if (sender_steady) return 0;
        case ($urandom_range(0, 99)) inside
            [0:64]:  return 0;
            [65:91]: return $urandom_range(1, 3);
            default: return $urandom_range(10, 40);
        endcase
    endfunction

    // A command with random content in every field; callers override what matters.
    function automatic term_cmd_t random_fields(logic [OP_W-1:0] op);
        term_cmd_t c;
        c.op          = op;
        c.code        = CHAR_W'($urandom);
        c.amount      = AMT_W'($urandom);
        c.clear_color = COLOR_W'($urandom);
        c.col         = COL_W'($urandom);
        c.row         = ROW_W'($urandom);
        return c;
    endfunction

    // Mostly text with occasional line breaks, reads and cursor moves; rare grid-wide work.
    function automatic term_cmd_t random_command();
        term_cmd_t c;
        int        pick;
        c    = random_fields(OP_PUT);
        pick = $urandom_range(0, 99);
        if (pick < 62) begin
            c.code = CHAR_W'($urandom_range(CHAR_FIRST, CHAR_LAST));
        end else if (pick < 67) begin
            c.code = CHAR_NL;
        end else if (pick < 69) begin
            c.code = CHAR_CR;
        end else if (pick < 72) begin
            c.code = ($urandom_range(0, 1) != 0) ?
                     CHAR_W'($urandom_range(CHAR_LAST + 1, {CHAR_W{1'b1}})) :
                     CHAR_W'($urandom_range(0, CHAR_FIRST - 1));
        end else if (pick < 86) begin
            c.op = OP_READ;
            if ($urandom_range(0, 9) < 8) begin
                c.col = COL_W'($urandom_range(0, COLS - 1));
                c.row = ROW_W'($urandom_range(0, ROWS - 1));
            end
        end else if (pick < 92) begin
            c.op = OP_SET_CUR;
            if ($urandom_range(0, 3) != 0) begin
                c.col = COL_W'($urandom_range(0, COLS - 1));
                c.row = ROW_W'($urandom_range(0, ROWS - 1));
            end
        end else if (pick < 94) begin
            c.op = OP_SCROLL;
            if ($urandom_range(0, 9) < 7)
                c.amount = ($urandom_range(0, 1) != 0) ? AMT_W'($urandom_range(1, 6))
                                                       : -AMT_W'($urandom_range(1, 6));
        end else if (pick < 95) begin
            c.op = OP_CLEAR;
        end else if (pick < 97) begin
            c.op = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
        end else begin
            c.code = CHAR_W'($urandom_range(CHAR_FIRST, CHAR_LAST));
        end
        return c;
    endfunction

    // Presents one command and waits for its transfer; valid is left high.
    task automatic send_command(term_cmd_t c);
        s_valid         <= 1'b1;
        s_op            <= c.op;
        s_char_code     <= c.code;
        s_scroll_amount <= c.amount;
        s_clear_color   <= c.clear_color;
        s_col           <= c.col;
        s_row           <= c.row;
        do @(posedge aclk); while (!s_ready);
        board.note_command(c);
    endtask

    task automatic issue(term_cmd_t c);
        int gap;
        send_command(c);
        gap = sender_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic put_code(logic [CHAR_W-1:0] code);
        term_cmd_t c;
        c      = random_fields(OP_PUT);
        c.code = code;
        issue(c);
    endtask

    task automatic at_cell(logic [OP_W-1:0] op, logic [COL_W-1:0] col, logic [ROW_W-1:0] row);
        term_cmd_t c;
        c     = random_fields(op);
        c.col = col;
        c.row = row;
        issue(c);
    endtask

    task automatic scroll_by(logic [AMT_W-1:0] amount);
        term_cmd_t c;
        c        = random_fields(OP_SCROLL);
        c.amount = amount;
        issue(c);
    endtask

    // Holds the sender until the block has returned every owed status.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
    endtask

    // Writes both color registers back to back; only called while the block is idle.
    task automatic write_colors(logic [COLOR_W-1:0] fg, logic [COLOR_W-1:0] bg);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_FG;
        cfg_data  <= fg;
        do @(posedge aclk); while (!cfg_ready);
        board.set_color(CFG_FG, fg);
        cfg_index <= CFG_BG;
        cfg_data  <= bg;
        do @(posedge aclk); while (!cfg_ready);
        board.set_color(CFG_BG, bg);
        cfg_valid <= 1'b0;
    endtask

    // Edge cases at reset colors: character classes, wrap, pending scroll, range limits.
    task automatic run_directed();
        term_cmd_t c;
        at_cell(OP_READ, '0, '0);
        put_code(CHAR_FIRST);
        put_code(CHAR_LAST);
        put_code(CHAR_W'(8'h41));
        put_code(CHAR_CR);
        put_code('0);
        put_code('1);
        at_cell(OP_READ, COL_W'(1), '0);
        put_code(CHAR_NL);
        at_cell(OP_SET_CUR, COL_W'(COLS - 1), ROW_W'(ROWS - 1));
        put_code(CHAR_W'(8'h5a));
        put_code(CHAR_W'(8'h61));
        at_cell(OP_READ, COL_W'(COLS - 1), ROW_W'(ROWS - 2));
        at_cell(OP_SET_CUR, '1, '1);
        put_code(CHAR_NL);
        at_cell(OP_READ, '1, '0);
        at_cell(OP_READ, '0, '1);
        scroll_by(AMT_W'(127));
        scroll_by(AMT_W'(-128));
        scroll_by(AMT_W'(1));
        scroll_by(-AMT_W'(1));
        scroll_by('0);
        c             = random_fields(OP_CLEAR);
        c.clear_color = '1;
        issue(c);
        at_cell(OP_READ, COL_W'(COLS - 1), ROW_W'(ROWS - 1));
        issue(random_fields(OP_SPARE_FIRST));
        issue(random_fields(OP_SPARE_LAST));
    endtask

    // Main sequence: reset, directed cases, then random phases under changing colors.
    initial begin : main_sequence
        logic [COLOR_W-1:0] fg_pick;
        logic [COLOR_W-1:0] bg_pick;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        run_directed();
        wait_idle();
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:       begin fg_pick = '1; bg_pick = '0; end
                1:       begin fg_pick = '0; bg_pick = '1; end
                2:       begin fg_pick = '1; bg_pick = '1; end
                3:       begin fg_pick = '0; bg_pick = '0; end
                default: begin
                    fg_pick = COLOR_W'($urandom);
                    bg_pick = COLOR_W'($urandom);
                end
            endcase
            write_colors(fg_pick, bg_pick);
            sender_steady = (phase % 3 == 1);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                issue(random_command());
            wait_idle();
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (board.pending() != 0)
            $display("ERROR: %0d results never arrived", board.pending());
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("ERROR: %0d mismatched results", board.mismatches);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
